[hdl/cpra_pkg.sv]
// Shared constants, codes and types for the chunk page run allocator.
package cpra_pkg;

  localparam int CHUNK_PAGES   = 64;
  localparam int INITIAL_PAGES = 8;
  localparam int PAGE_W        = $clog2(CHUNK_PAGES);
  localparam int CNT_W         = PAGE_W + 1;
  localparam int KIND_W        = 3;

  localparam logic [CNT_W-1:0]  CHUNK_CNT = CNT_W'(CHUNK_PAGES);
  localparam logic [CNT_W-1:0]  INIT_CNT  =
      (INITIAL_PAGES < CHUNK_PAGES) ? CNT_W'(INITIAL_PAGES) : CNT_W'(CHUNK_PAGES);
  localparam logic [PAGE_W-1:0] PAGE_LAST = PAGE_W'(CHUNK_PAGES - 1);

  localparam logic [1:0] FN_LARGE = 2'd0;
  localparam logic [1:0] FN_SMALL = 2'd1;
  localparam logic [1:0] FN_FREE  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [KIND_W-1:0] {
    PK_FREE   = 3'd0,
    PK_HEADER = 3'd1,
    PK_LHEAD  = 3'd2,
    PK_LFRAG  = 3'd3,
    PK_SHEAD  = 3'd4,
    PK_SFRAG  = 3'd5
  } kind_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_LSCAN,
    S_SSCAN,
    S_GCHK,
    S_GROW,
    S_LBACK,
    S_MARK,
    S_FREAD,
    S_FCLR,
    S_OWN,
    S_FIN
  } state_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    kind_t             wdata;
    logic [PAGE_W-1:0] raddr;
  } kind_req_t;

  typedef struct packed {
    logic              we;
    logic [PAGE_W-1:0] waddr;
    logic [CNT_W-1:0]  wdata;
    logic [PAGE_W-1:0] raddr;
  } len_req_t;

endpackage

[hdl/cpra_in_if.sv]
// Request channel: function code, page count and page index.
interface cpra_in_if;
  import cpra_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [CNT_W-1:0]  page_count;
  logic [PAGE_W-1:0] page_index;
  modport source(output valid, func, page_count, page_index, input ready);
  modport sink(input valid, func, page_count, page_index, output ready);
endinterface

[hdl/cpra_out_if.sv]
// Result channel: status, placed page, owner page, flags and counters.
interface cpra_out_if;
  import cpra_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [PAGE_W-1:0] start_page;
  logic [PAGE_W-1:0] small_owner_page;
  logic              is_small_free;
  logic              became_full;
  logic              became_available;
  logic [CNT_W-1:0]  pages_allocated;
  logic [PAGE_W-1:0] pages_free;
  modport source(output valid, status, start_page, small_owner_page, is_small_free,
                 became_full, became_available, pages_allocated, pages_free,
                 input ready);
  modport sink(input valid, status, start_page, small_owner_page, is_small_free,
               became_full, became_available, pages_allocated, pages_free,
               output ready);
endinterface

[hdl/cpra_cfg_if.sv]
// Configuration write channel for the deepest_chunk register.
interface cpra_cfg_if;
  logic valid;
  logic ready;
  logic data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

[hdl/cpra_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
module cpra_ram #(
  parameter int AW = 6,
  parameter int DW = 3
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

[hdl/cpra_ctrl.sv]
// Sequencer: page map scans, growth, run marking, frees and the result register.
module cpra_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  cpra_in_if.sink                  in_ch,
  cpra_out_if.source               out_ch,
  cpra_cfg_if.sink                 cfg_ch,
  output cpra_pkg::kind_req_t      kind_req,
  input  logic [cpra_pkg::KIND_W-1:0] kind_rdata,
  output cpra_pkg::len_req_t       len_req,
  input  logic [cpra_pkg::CNT_W-1:0]  len_rdata
);
  import cpra_pkg::*;

  state_t            state_r, state_nxt;
  logic              deepest_r;
  logic [1:0]        func_r, func_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [CNT_W-1:0]  alloc_r, alloc_nxt;
  logic [CNT_W-1:0]  free_r, free_nxt;
  logic [CNT_W-1:0]  old_r, old_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [PAGE_W-1:0] pidx_r, pidx_nxt;
  logic              pval_r, pval_nxt;
  logic [CNT_W-1:0]  run_r, run_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [PAGE_W-1:0] start_r, start_nxt;
  logic [PAGE_W-1:0] owner_r, owner_nxt;
  logic              small_r, small_nxt;
  logic              avail_r, avail_nxt;

  logic              ov_r, ov_nxt;
  logic [1:0]        o_status_r, o_status_nxt;
  logic [PAGE_W-1:0] o_start_r, o_start_nxt;
  logic [PAGE_W-1:0] o_owner_r, o_owner_nxt;
  logic              o_small_r, o_small_nxt;
  logic              o_full_r, o_full_nxt;
  logic              o_avail_r, o_avail_nxt;
  logic [CNT_W-1:0]  o_alloc_r, o_alloc_nxt;
  logic [PAGE_W-1:0] o_free_r, o_free_nxt;

  kind_t             kind_rd;
  logic              in_fire, out_slot, is_free, l_hit, l_issue, s_issue;
  logic              lback_hit, own_hit, mark_last, can_grow, grow_done, fits_pre;
  logic              full_now;
  logic [CNT_W-1:0]  run_inc, grown, alloc_grow;
  logic [CNT_W:0]    grow_cand;

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_slot  = !ov_r || out_ch.ready;

  assign kind_rd   = kind_t'(kind_rdata);
  assign is_free   = (kind_rd == PK_FREE);
  assign run_inc   = run_r + CNT_W'(1);
  assign l_hit     = pval_r && is_free && (run_inc == cnt_r);
  assign l_issue   = (idx_r < alloc_r);
  assign s_issue   = (idx_r != '0);
  assign lback_hit = pval_r && !is_free;
  assign own_hit   = pval_r && (kind_rd != PK_SFRAG);
  assign mark_last = (run_r == CNT_W'(1)) || (idx_r[PAGE_W-1:0] == PAGE_LAST);
  assign can_grow  = (CHUNK_CNT - alloc_r) > cnt_r;
  assign grown     = alloc_r - old_r;
  assign grow_done = (grown >= cnt_r);
  assign full_now  = (free_r == '0) && (alloc_r == CHUNK_CNT);
  assign fits_pre  = (in_ch.func == FN_LARGE) ? (in_ch.page_count <= free_r)
                                              : (in_ch.page_count < free_r);

  // Doubling stops at the chunk size; a non-deepest chunk jumps straight there.
  assign grow_cand  = deepest_r ? {alloc_r, 1'b0} : {1'b0, CHUNK_CNT};
  assign alloc_grow = (grow_cand > {1'b0, CHUNK_CNT} || grow_cand <= {1'b0, alloc_r})
                      ? CHUNK_CNT : grow_cand[CNT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      deepest_r <= 1'b1;
      alloc_r   <= INIT_CNT;
      free_r    <= INIT_CNT - CNT_W'(1);
      idx_r     <= '0;
      pval_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      free_r  <= free_nxt;
      idx_r   <= idx_nxt;
      pval_r  <= pval_nxt;
      ov_r    <= ov_nxt;
      if (cfg_ch.valid) begin
        deepest_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_nxt;
    cnt_r      <= cnt_nxt;
    page_r     <= page_nxt;
    old_r      <= old_nxt;
    pidx_r     <= pidx_nxt;
    run_r      <= run_nxt;
    status_r   <= status_nxt;
    start_r    <= start_nxt;
    owner_r    <= owner_nxt;
    small_r    <= small_nxt;
    avail_r    <= avail_nxt;
    o_status_r <= o_status_nxt;
    o_start_r  <= o_start_nxt;
    o_owner_r  <= o_owner_nxt;
    o_small_r  <= o_small_nxt;
    o_full_r   <= o_full_nxt;
    o_avail_r  <= o_avail_nxt;
    o_alloc_r  <= o_alloc_nxt;
    o_free_r   <= o_free_nxt;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: begin
        if (idx_r[PAGE_W-1:0] == PAGE_LAST) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.func)
            FN_LARGE, FN_SMALL: begin
              if (in_ch.page_count == '0) state_nxt = S_FIN;
              else if (!fits_pre) state_nxt = S_GCHK;
              else if (in_ch.func == FN_LARGE) state_nxt = S_LSCAN;
              else state_nxt = S_SSCAN;
            end
            FN_FREE: begin
              state_nxt = ({1'b0, in_ch.page_index} < alloc_r) ? S_FREAD : S_FIN;
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_LSCAN: begin
        if (l_hit) state_nxt = S_MARK;
        else if (!pval_r && !l_issue) state_nxt = S_GCHK;
      end
      S_SSCAN: begin
        if (l_hit) state_nxt = S_MARK;
        else if (!pval_r && !s_issue) state_nxt = S_GCHK;
      end
      S_GCHK: begin
        state_nxt = can_grow ? S_GROW : S_FIN;
      end
      S_GROW: begin
        if (grow_done) state_nxt = (func_r == FN_LARGE) ? S_LBACK : S_MARK;
      end
      S_LBACK: begin
        if (lback_hit || (!pval_r && !s_issue)) state_nxt = S_MARK;
      end
      S_MARK: begin
        if (mark_last) state_nxt = S_FIN;
      end
      S_FREAD: begin
        case (kind_rd)
          PK_LHEAD: state_nxt = (len_rdata == '0) ? S_FIN : S_FCLR;
          PK_SFRAG: state_nxt = S_OWN;
          default:  state_nxt = S_FIN;
        endcase
      end
      S_FCLR: begin
        if (mark_last) state_nxt = S_FIN;
      end
      S_OWN: begin
        if (own_hit) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_slot) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath, memory ports and result register
  always_comb begin
    func_nxt   = func_r;
    cnt_nxt    = cnt_r;
    page_nxt   = page_r;
    alloc_nxt  = alloc_r;
    free_nxt   = free_r;
    old_nxt    = old_r;
    idx_nxt    = idx_r;
    pidx_nxt   = pidx_r;
    pval_nxt   = 1'b0;
    run_nxt    = run_r;
    status_nxt = status_r;
    start_nxt  = start_r;
    owner_nxt  = owner_r;
    small_nxt  = small_r;
    avail_nxt  = avail_r;

    ov_nxt       = ov_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_start_nxt  = o_start_r;
    o_owner_nxt  = o_owner_r;
    o_small_nxt  = o_small_r;
    o_full_nxt   = o_full_r;
    o_avail_nxt  = o_avail_r;
    o_alloc_nxt  = o_alloc_r;
    o_free_nxt   = o_free_r;

    kind_req.we    = 1'b0;
    kind_req.waddr = idx_r[PAGE_W-1:0];
    kind_req.wdata = PK_FREE;
    kind_req.raddr = idx_r[PAGE_W-1:0];
    len_req.we     = 1'b0;
    len_req.waddr  = idx_r[PAGE_W-1:0];
    len_req.wdata  = cnt_r;
    len_req.raddr  = in_ch.page_index;

    case (state_r)
      S_CLEAR: begin
        kind_req.we    = 1'b1;
        kind_req.wdata = (idx_r == '0) ? PK_HEADER : PK_FREE;
        idx_nxt        = idx_r + CNT_W'(1);
      end
      S_IDLE: begin
        kind_req.raddr = in_ch.page_index;
        if (in_fire) begin
          func_nxt   = in_ch.func;
          cnt_nxt    = in_ch.page_count;
          page_nxt   = in_ch.page_index;
          run_nxt    = '0;
          status_nxt = ST_OK;
          start_nxt  = '0;
          owner_nxt  = '0;
          small_nxt  = 1'b0;
          avail_nxt  = 1'b0;
          idx_nxt    = (in_ch.func == FN_LARGE) ? CNT_W'(1) : alloc_r;
          case (in_ch.func)
            FN_LARGE, FN_SMALL: begin
              if (in_ch.page_count == '0) status_nxt = ST_NOFIT;
            end
            FN_FREE: begin
              if ({1'b0, in_ch.page_index} >= alloc_r) status_nxt = ST_BADFREE;
            end
            default: status_nxt = ST_OK;
          endcase
        end
      end
      S_LSCAN: begin
        if (l_issue) begin
          pval_nxt = 1'b1;
          pidx_nxt = idx_r[PAGE_W-1:0];
          idx_nxt  = idx_r + CNT_W'(1);
        end
        if (pval_r) begin
          run_nxt = is_free ? run_inc : '0;
          if (l_hit) begin
            start_nxt = PAGE_W'({1'b0, pidx_r} + CNT_W'(1) - cnt_r);
            idx_nxt   = {1'b0, pidx_r} + CNT_W'(1) - cnt_r;
            run_nxt   = cnt_r;
            free_nxt  = free_r - cnt_r;
          end
        end
      end
      S_SSCAN: begin
        kind_req.raddr = PAGE_W'(idx_r - CNT_W'(1));
        if (s_issue) begin
          pval_nxt = 1'b1;
          pidx_nxt = PAGE_W'(idx_r - CNT_W'(1));
          idx_nxt  = idx_r - CNT_W'(1);
        end
        if (pval_r) begin
          run_nxt = is_free ? run_inc : '0;
          if (l_hit) begin
            start_nxt = pidx_r;
            idx_nxt   = {1'b0, pidx_r};
            run_nxt   = cnt_r;
            free_nxt  = free_r - cnt_r;
          end
        end
      end
      S_GCHK: begin
        old_nxt = alloc_r;
        if (!can_grow) status_nxt = ST_NOFIT;
      end
      S_GROW: begin
        if (grow_done) begin
          if (func_r == FN_LARGE) begin
            free_nxt = free_r + grown;
            idx_nxt  = old_r;
          end else begin
            free_nxt  = free_r + grown - cnt_r;
            start_nxt = PAGE_W'(alloc_r - cnt_r);
            idx_nxt   = alloc_r - cnt_r;
            run_nxt   = cnt_r;
          end
        end else begin
          alloc_nxt = alloc_grow;
        end
      end
      S_LBACK: begin
        // Walk down from the old top to the highest page in use.
        if (s_issue) begin
          pval_nxt = 1'b1;
          pidx_nxt = idx_r[PAGE_W-1:0];
          idx_nxt  = idx_r - CNT_W'(1);
        end
        if (lback_hit || (!pval_r && !s_issue)) begin
          start_nxt = lback_hit ? pidx_r + PAGE_W'(1) : PAGE_W'(1);
          idx_nxt   = lback_hit ? {1'b0, pidx_r} + CNT_W'(1) : CNT_W'(1);
          run_nxt   = cnt_r;
          free_nxt  = free_r - cnt_r;
          pval_nxt  = 1'b0;
        end
      end
      S_MARK: begin
        kind_req.we = 1'b1;
        if (idx_r[PAGE_W-1:0] == start_r) begin
          kind_req.wdata = (func_r == FN_LARGE) ? PK_LHEAD : PK_SHEAD;
          len_req.we     = (func_r == FN_LARGE);
        end else begin
          kind_req.wdata = (func_r == FN_LARGE) ? PK_LFRAG : PK_SFRAG;
        end
        idx_nxt = idx_r + CNT_W'(1);
        run_nxt = run_r - CNT_W'(1);
      end
      S_FREAD: begin
        case (kind_rd)
          PK_LHEAD: begin
            avail_nxt = full_now && (len_rdata != '0);
            free_nxt  = free_r + len_rdata;
            idx_nxt   = {1'b0, page_r};
            run_nxt   = len_rdata;
          end
          PK_SHEAD: begin
            owner_nxt = page_r;
            small_nxt = 1'b1;
          end
          PK_SFRAG: begin
            small_nxt = 1'b1;
            idx_nxt   = {1'b0, page_r};
          end
          default: status_nxt = ST_BADFREE;
        endcase
      end
      S_FCLR: begin
        kind_req.we    = 1'b1;
        kind_req.wdata = PK_FREE;
        idx_nxt        = idx_r + CNT_W'(1);
        run_nxt        = run_r - CNT_W'(1);
      end
      S_OWN: begin
        // Page 0 holds the header, so the walk always stops.
        kind_req.raddr = PAGE_W'(idx_r - CNT_W'(1));
        if (s_issue) begin
          pval_nxt = 1'b1;
          pidx_nxt = PAGE_W'(idx_r - CNT_W'(1));
          idx_nxt  = idx_r - CNT_W'(1);
        end
        if (own_hit) begin
          owner_nxt = pidx_r;
          pval_nxt  = 1'b0;
        end
      end
      S_FIN: begin
        if (out_slot) begin
          ov_nxt       = 1'b1;
          o_status_nxt = status_r;
          o_start_nxt  = start_r;
          o_owner_nxt  = owner_r;
          o_small_nxt  = small_r;
          o_full_nxt   = (func_r == FN_LARGE || func_r == FN_SMALL) &&
                         (status_r == ST_OK) && full_now;
          o_avail_nxt  = avail_r;
          o_alloc_nxt  = alloc_r;
          o_free_nxt   = free_r[PAGE_W-1:0];
        end
      end
      default: begin
        idx_nxt = idx_r;
      end
    endcase
  end

  assign out_ch.valid            = ov_r;
  assign out_ch.status           = o_status_r;
  assign out_ch.start_page       = o_start_r;
  assign out_ch.small_owner_page = o_owner_r;
  assign out_ch.is_small_free    = o_small_r;
  assign out_ch.became_full      = o_full_r;
  assign out_ch.became_available = o_avail_r;
  assign out_ch.pages_allocated  = o_alloc_r;
  assign out_ch.pages_free       = o_free_r;
endmodule

[hdl/chunk_page_run_allocator.sv]
// Top level of the chunk page run allocator: page map, run length store, sequencer.
// One request is worked at a time. After reset a clearing pass writes the page map,
// during which no request is taken. A large allocation scans the page map upward
// one page per cycle through its single read port, a small one scans it downward,
// and the run is then written into the page map one page per cycle; growth raises
// the grown page count and, for large runs, adds a downward scan from the old top.
// A large free clears its run in the page map, a small free of a fragment walks
// back to the run head. The result is held in an output register, so the next
// request may be taken while it waits.
module chunk_page_run_allocator (
  input  logic        clk,
  input  logic        rst_n,
  cpra_in_if.sink     in_ch,
  cpra_out_if.source  out_ch,
  cpra_cfg_if.sink    cfg_ch
);
  import cpra_pkg::*;

  kind_req_t         kind_req;
  len_req_t          len_req;
  logic [KIND_W-1:0] kind_rdata;
  logic [CNT_W-1:0]  len_rdata;

  cpra_ram #(.AW(PAGE_W), .DW(KIND_W)) u_kind_ram (
    .clk   (clk),
    .we    (kind_req.we),
    .waddr (kind_req.waddr),
    .wdata (kind_req.wdata),
    .raddr (kind_req.raddr),
    .rdata (kind_rdata)
  );

  cpra_ram #(.AW(PAGE_W), .DW(CNT_W)) u_len_ram (
    .clk   (clk),
    .we    (len_req.we),
    .waddr (len_req.waddr),
    .wdata (len_req.wdata),
    .raddr (len_req.raddr),
    .rdata (len_rdata)
  );

  cpra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_ch     (cfg_ch),
    .kind_req   (kind_req),
    .kind_rdata (kind_rdata),
    .len_req    (len_req),
    .len_rdata  (len_rdata)
  );
endmodule

[tb/sv/chunk_page_run_allocator_tb.sv]
// Self-checking testbench for the chunk page run allocator: page map predictor and scoreboard.
module chunk_page_run_allocator_tb;
  import cpra_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FN_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 850;

  typedef struct packed {
    logic [1:0]        status;
    logic [PAGE_W-1:0] start_page;
    logic [PAGE_W-1:0] small_owner_page;
    logic              is_small_free;
    logic              became_full;
    logic              became_available;
    logic [CNT_W-1:0]  pages_allocated;
    logic [PAGE_W-1:0] pages_free;
  } alloc_result_t;

  class alloc_scoreboard;
    kind_t         kind_map[CHUNK_PAGES];
    int            run_len[CHUNK_PAGES];
    int            grown;
    int            free_cnt;
    bit            deepest;
    alloc_result_t expected_q[$];
    int            errors;

    function new();
      foreach (kind_map[i]) begin
        kind_map[i] = PK_FREE;
        run_len[i] = 0;
      end
      kind_map[0] = PK_HEADER;
      grown = int'(INIT_CNT);
      free_cnt = grown - 1;
      deepest = 1'b1;
      errors = 0;
    endfunction

    function bit is_full();
      return free_cnt == 0 && grown == CHUNK_PAGES;
    endfunction

    function int grow_by(int n);
      int old;
      int next;
      old = grown;
      while (grown - old < n) begin
        next = deepest ? grown * 2 : CHUNK_PAGES;
        if (next > CHUNK_PAGES || next <= grown) next = CHUNK_PAGES;
        grown = next;
      end
      free_cnt += grown - old;
      return old;
    endfunction

    function void mark_run(int first, int n, kind_t head, kind_t frag);
      kind_map[first] = head;
      for (int j = 1; j < n && first + j < CHUNK_PAGES; j++) kind_map[first + j] = frag;
    endfunction

    function bit place_large(int n, output int first);
      int run;
      int old;
      run = 0;
      first = 0;
      if (n == 0) return 1'b0;
      if (n <= free_cnt) begin
        for (int i = 1; i < grown; i++) begin
          if (kind_map[i] == PK_FREE) begin
            run++;
            if (run == n) begin
              first = i + 1 - n;
              mark_run(first, n, PK_LHEAD, PK_LFRAG);
              run_len[first] = n;
              free_cnt -= n;
              return 1'b1;
            end
          end else begin
            run = 0;
          end
        end
      end
      if (CHUNK_PAGES - grown > n) begin
        old = grow_by(n);
        first = 1;
        for (int i = old; i > 0; i--) begin
          if (kind_map[i] != PK_FREE) begin
            first = i + 1;
            break;
          end
        end
        mark_run(first, n, PK_LHEAD, PK_LFRAG);
        run_len[first] = n;
        free_cnt -= n;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function bit place_small(int n, output int first);
      int run;
      run = 0;
      first = 0;
      if (n == 0) return 1'b0;
      if (n < free_cnt) begin
        for (int i = grown; i > 0; i--) begin
          if (kind_map[i-1] == PK_FREE) begin
            run++;
            if (run == n) begin
              first = i - 1;
              mark_run(first, n, PK_SHEAD, PK_SFRAG);
              free_cnt -= n;
              return 1'b1;
            end
          end else begin
            run = 0;
          end
        end
      end
      if (CHUNK_PAGES - grown > n) begin
        void'(grow_by(n));
        first = grown - n;
        mark_run(first, n, PK_SHEAD, PK_SFRAG);
        free_cnt -= n;
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void note_request(logic [1:0] func, logic [CNT_W-1:0] count,
                               logic [PAGE_W-1:0] idx);
      alloc_result_t r;
      int first;
      int len;
      int owner;
      kind_t k;
      bit ok;
      r = '0;
      first = 0;
      if (func == FN_LARGE || func == FN_SMALL) begin
        ok = (func == FN_LARGE) ? place_large(int'(count), first)
                                : place_small(int'(count), first);
        if (ok) begin
          r.start_page = first[PAGE_W-1:0];
          r.became_full = is_full();
        end else begin
          r.status = ST_NOFIT;
        end
      end else if (func == FN_FREE) begin
        k = (int'(idx) < grown) ? kind_map[idx] : PK_FREE;
        if (k == PK_LHEAD) begin
          len = run_len[idx];
          for (int i = 0; i < len && int'(idx) + i < CHUNK_PAGES; i++)
            kind_map[int'(idx) + i] = PK_FREE;
          r.became_available = is_full() && len > 0;
          free_cnt += len;
        end else if (k == PK_SHEAD || k == PK_SFRAG) begin
          owner = int'(idx);
          while (owner > 0 && kind_map[owner] == PK_SFRAG) owner--;
          r.small_owner_page = owner[PAGE_W-1:0];
          r.is_small_free = 1'b1;
        end else begin
          r.status = ST_BADFREE;
        end
      end
      r.pages_allocated = grown[CNT_W-1:0];
      r.pages_free = free_cnt[PAGE_W-1:0];
      expected_q.push_back(r);
    endfunction

    function void cmp(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
        errors++;
      end
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("status", e.status, got.status);
      cmp("start_page", e.start_page, got.start_page);
      cmp("small_owner_page", e.small_owner_page, got.small_owner_page);
      cmp("is_small_free", e.is_small_free, got.is_small_free);
      cmp("became_full", e.became_full, got.became_full);
      cmp("became_available", e.became_available, got.became_available);
      cmp("pages_allocated", e.pages_allocated, got.pages_allocated);
      cmp("pages_free", e.pages_free, got.pages_free);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   in_idle = 0;
  int   out_idle = 0;
  alloc_scoreboard sb = new();

  cpra_in_if  in_ch();
  cpra_out_if out_ch();
  cpra_cfg_if cfg_ch();

  chunk_page_run_allocator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stalls at the falling edge, checks at the rising edge
  initial out_ch.ready = 1'b0;
  always @(negedge clk) out_ch.ready = rst_n && ($urandom_range(0, 99) >= out_idle);
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result({out_ch.status, out_ch.start_page, out_ch.small_owner_page,
                       out_ch.is_small_free, out_ch.became_full, out_ch.became_available,
                       out_ch.pages_allocated, out_ch.pages_free});
  end

  task automatic send_req(logic [1:0] func, logic [CNT_W-1:0] count, logic [PAGE_W-1:0] idx);
    while ($urandom_range(0, 99) < in_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.func = func;
    in_ch.page_count = count;
    in_ch.page_index = idx;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(func, count, idx);
    @(negedge clk);
  endtask

  task automatic write_deepest(logic value);
    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.deepest = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // pick a page inside a live run most of the time so frees do real work
  function automatic logic [PAGE_W-1:0] pick_run_page();
    int live[$];
    for (int i = 0; i < CHUNK_PAGES; i++)
      if (sb.kind_map[i] == PK_LHEAD || sb.kind_map[i] == PK_SHEAD ||
          sb.kind_map[i] == PK_SFRAG) live.push_back(i);
    if (live.size() == 0) return PAGE_W'($urandom_range(0, CHUNK_PAGES - 1));
    return PAGE_W'(live[$urandom_range(0, live.size() - 1)]);
  endfunction

  task automatic random_phase(int n);
    int sel;
    logic [CNT_W-1:0] cnt;
    for (int k = 0; k < n; k++) begin
      sel = $urandom_range(0, 99);
      cnt = ($urandom_range(0, 9) == 0) ? CNT_W'($urandom_range(0, 127))
                                        : CNT_W'($urandom_range(1, 8));
      if (sel < 30) send_req(FN_LARGE, cnt, PAGE_W'($urandom));
      else if (sel < 55) send_req(FN_SMALL, cnt, PAGE_W'($urandom));
      else if (sel < 90) send_req(FN_FREE, CNT_W'($urandom), pick_run_page());
      else if (sel < 96) send_req(FN_FREE, CNT_W'($urandom), PAGE_W'($urandom));
      else send_req(FN_UNUSED, CNT_W'($urandom), PAGE_W'($urandom));
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = FN_LARGE;
    in_ch.page_count = '0;
    in_ch.page_index = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = 1'b0;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    write_deepest(1'b1);
    send_req(FN_LARGE, 7'd0, 6'd0);
    send_req(FN_SMALL, 7'd0, 6'd63);
    send_req(FN_UNUSED, 7'd127, 6'd63);
    send_req(FN_LARGE, 7'd2, 6'd0);
    send_req(FN_SMALL, 7'd1, 6'd0);
    send_req(FN_FREE, 7'd0, 6'd2);     // large fragment
    send_req(FN_FREE, 7'd0, 6'd0);     // header
    send_req(FN_FREE, 7'd0, 6'd63);    // outside grown pages
    send_req(FN_FREE, 7'd0, 6'd5);     // free page
    send_req(FN_FREE, 7'd0, 6'd7);     // small run head
    send_req(FN_LARGE, 7'd127, 6'd0);  // oversized
    send_req(FN_LARGE, 7'd64, 6'd0);
    send_req(FN_LARGE, 7'd10, 6'd0);   // doubles 8 -> 32
    send_req(FN_SMALL, 7'd3, 6'd0);
    send_req(FN_FREE, 7'd0, 6'd1);
    send_req(FN_FREE, 7'd0, PAGE_W'(sb.grown - 2)); // small fragment
    write_deepest(1'b0);
    send_req(FN_SMALL, 7'd20, 6'd0);   // jumps to the full chunk
    send_req(FN_LARGE, CNT_W'(sb.free_cnt), 6'd0);
    send_req(FN_FREE, 7'd0, pick_run_page());
    send_req(FN_LARGE, 7'd1, 6'd0);
    send_req(FN_FREE, 7'd0, 6'd1);

    in_idle = 19;
    out_idle = 55;
    write_deepest(1'b1);
    random_phase(RANDOM_ITEMS / 3);
    in_idle = 55;
    out_idle = 19;
    write_deepest(1'b0);
    random_phase(RANDOM_ITEMS / 3);
    in_idle = 0;
    out_idle = 0;
    write_deepest(1'b1);
    random_phase(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));

    in_ch.valid = 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/cpra_pkg.sv
hdl/cpra_in_if.sv
hdl/cpra_out_if.sv
hdl/cpra_cfg_if.sv
hdl/cpra_ram.sv
hdl/cpra_ctrl.sv
hdl/chunk_page_run_allocator.sv
tb/sv/chunk_page_run_allocator_tb.sv
